// ----- sv/selective_repeat_receive_window_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the selective-repeat receive window
// Shared property forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef SELECTIVE_REPEAT_RECEIVE_WINDOW_ASSERT_SVH
`define SELECTIVE_REPEAT_RECEIVE_WINDOW_ASSERT_SVH

// next-cycle implication, off while reset is high
`define SRRW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// next-cycle implication that also holds across reset
`define SRRW_ASSERT_NEXT_NR(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/srrw_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srrw_pkg
// Types, codes and helpers of the selective-repeat receive window.
// ----------------------------------------------------------------------------
package srrw_pkg;

   localparam int MAX_WINDOW_DEF = 16;

   localparam int SEQ_W       = 16;
   localparam int TAG_W       = 16;
   localparam int SIZE_W      = 13;
   localparam int SLOTS_W     = 5;
   localparam int STEP_W      = 13;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_SLOTS = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SEQ_STEP     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SEQ_LIMIT    = 2'd2;

   // register reset values
   localparam logic [SLOTS_W-1:0] WINDOW_SLOTS_RST = 5'd5;
   localparam logic [STEP_W-1:0]  SEQ_STEP_RST     = 13'd1024;
   localparam logic [SEQ_W-1:0]   SEQ_LIMIT_RST    = 16'd30720;

   // result kinds
   localparam logic KIND_DELIVER = 1'b0;
   localparam logic KIND_ACK     = 1'b1;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_SEARCH,
      ST_SL_RD,
      ST_SL_OUT,
      ST_ACK
   } state_type;

   typedef struct packed {
      logic [TAG_W-1:0]  tag;
      logic [SIZE_W-1:0] size;
      logic              fin;
   } slot_data_type;

   // next sequence number, zero once it would pass the limit
   function automatic logic [SEQ_W-1:0] advance_seq(input logic [SEQ_W-1:0]  s,
                                                    input logic [STEP_W-1:0] step,
                                                    input logic [SEQ_W-1:0]  limit);
      logic [SEQ_W:0] n;
      n = {1'b0, s} + {{(SEQ_W + 1 - STEP_W){1'b0}}, step};
      return (n <= {1'b0, limit}) ? n[SEQ_W-1:0] : '0;
   endfunction

endpackage
`default_nettype wire

// ----- sv/selective_repeat_receive_window.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// selective_repeat_receive_window
// Receiver window of selective-repeat ARQ: match, in-order slide, ack.
// ----------------------------------------------------------------------------
// Usage
//  - req_*: one packet descriptor per item (seq, fin, size, tag).
//  - rsp_*: per item, one delivery per in-order slot released from the window
//    head, then one ack for the arriving seq (rsp_last_result marks it).
//  - csr_*: register writes (index, data); always ready. Any write of a known
//    register restarts the window and clears the done flag.
//  - One item at a time. The slot-seq memory has one read port, so the
//    search walks one slot per cycle and each delivery is a read then a
//    write-back.
//  - After reset or a write of a known register an init sweep writes the
//    W expected sequence numbers with req_ready low.
//  - Once a FIN is delivered, items are taken and dropped with no result.
//  - A stalled rsp_ready holds the result register and the slide; the next
//    item can be taken while the ack still waits.
// ----------------------------------------------------------------------------
module selective_repeat_receive_window #(
   parameter int MAX_WINDOW = srrw_pkg::MAX_WINDOW_DEF
) (
   input  wire                                  clock,
   input  wire                                  reset,
   // packet descriptors
   input  wire                                  req_valid,
   output logic                                 req_ready,
   input  wire  [srrw_pkg::SEQ_W-1:0]           req_pkt_seq,
   input  wire                                  req_pkt_is_fin,
   input  wire  [srrw_pkg::SIZE_W-1:0]          req_pkt_size,
   input  wire  [srrw_pkg::TAG_W-1:0]           req_pkt_tag,
   // results
   output logic                                 rsp_valid,
   input  wire                                  rsp_ready,
   output logic                                 rsp_result_kind,
   output logic [srrw_pkg::SEQ_W-1:0]           rsp_out_seq,
   output logic [srrw_pkg::TAG_W-1:0]           rsp_out_tag,
   output logic [srrw_pkg::SIZE_W-1:0]          rsp_out_size,
   output logic                                 rsp_out_is_fin,
   output logic                                 rsp_transfer_done,
   output logic                                 rsp_last_result,
   // registers
   input  wire                                  csr_valid,
   output logic                                 csr_ready,
   input  wire  [srrw_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire  [srrw_pkg::CSR_DATA_W-1:0]      csr_data
);

   localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int CNT_W = $clog2(MAX_WINDOW + 1);

   // registers
   logic [srrw_pkg::SLOTS_W-1:0] win_slots_ff, win_slots_in;
   logic [srrw_pkg::STEP_W-1:0]  seq_step_ff, seq_step_in;
   logic [srrw_pkg::SEQ_W-1:0]   seq_limit_ff, seq_limit_in;

   // control
   srrw_pkg::state_type          state_ff, state_in;
   logic [IDX_W-1:0]             init_k_ff, init_k_in;
   logic [srrw_pkg::SEQ_W-1:0]   init_s_ff, init_s_in;
   logic [IDX_W-1:0]             head_ff, head_in;
   logic                         done_ff, done_in;
   logic [MAX_WINDOW-1:0]        rcvd_ff, rcvd_in;
   logic                         chk_vld_ff, chk_vld_in;
   logic                         rsp_valid_ff, rsp_valid_in;

   // payload
   logic [srrw_pkg::SEQ_W-1:0]   next_exp_ff, next_exp_in;
   logic [srrw_pkg::SEQ_W-1:0]   pkt_seq_ff, pkt_seq_in;
   logic                         pkt_fin_ff, pkt_fin_in;
   logic [srrw_pkg::SIZE_W-1:0]  pkt_size_ff, pkt_size_in;
   logic [srrw_pkg::TAG_W-1:0]   pkt_tag_ff, pkt_tag_in;
   logic [IDX_W-1:0]             iss_p_ff, iss_p_in;
   logic [CNT_W-1:0]             iss_k_ff, iss_k_in;
   logic [IDX_W-1:0]             chk_p_ff, chk_p_in;
   logic                         chk_last_ff, chk_last_in;
   logic                         rsp_kind_ff, rsp_kind_in;
   logic [srrw_pkg::SEQ_W-1:0]   rsp_seq_ff, rsp_seq_in;
   logic [srrw_pkg::TAG_W-1:0]   rsp_tag_ff, rsp_tag_in;
   logic [srrw_pkg::SIZE_W-1:0]  rsp_size_ff, rsp_size_in;
   logic                         rsp_fin_ff, rsp_fin_in;
   logic                         rsp_done_ff, rsp_done_in;
   logic                         rsp_last_ff, rsp_last_in;

   // memories: expected seq per slot, stored packet per slot
   logic [srrw_pkg::SEQ_W-1:0]   seq_mem [MAX_WINDOW];
   logic [srrw_pkg::SEQ_W-1:0]   seq_rdata_ff;
   srrw_pkg::slot_data_type      dat_mem [MAX_WINDOW];
   srrw_pkg::slot_data_type      dat_rdata_ff;

   logic                         seq_we, seq_re;
   logic [IDX_W-1:0]             seq_waddr, seq_raddr;
   logic [srrw_pkg::SEQ_W-1:0]   seq_wdata;
   logic                         dat_we, dat_re;
   logic [IDX_W-1:0]             dat_waddr, dat_raddr;
   srrw_pkg::slot_data_type      dat_wdata;

   logic [CNT_W-1:0]             win_len;
   logic                         rsp_free;
   logic                         csr_fire;
   logic                         delivered_fin;

   // W clamped to 1 .. MAX_WINDOW
   always_comb begin
      if (win_slots_ff == '0) begin
         win_len = CNT_W'(1);
      end else if (win_slots_ff > MAX_WINDOW) begin
         win_len = CNT_W'(MAX_WINDOW);
      end else begin
         win_len = CNT_W'(win_slots_ff);
      end
   end

   // circular slot index step within the active window
   function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] p,
                                                 input logic [CNT_W-1:0] len);
      if (CNT_W'(p) == len - CNT_W'(1)) begin
         return '0;
      end
      return p + IDX_W'(1);
   endfunction

   assign rsp_free      = !rsp_valid_ff || rsp_ready;
   assign csr_ready     = 1'b1;
   assign csr_fire      = csr_valid && csr_ready;
   assign delivered_fin = dat_rdata_ff.fin;

   always_comb begin
      logic reinit;
      reinit       = 1'b0;
      state_in     = state_ff;
      win_slots_in = win_slots_ff;
      seq_step_in  = seq_step_ff;
      seq_limit_in = seq_limit_ff;
      init_k_in    = init_k_ff;
      init_s_in    = init_s_ff;
      head_in      = head_ff;
      done_in      = done_ff;
      rcvd_in      = rcvd_ff;
      chk_vld_in   = chk_vld_ff;
      next_exp_in  = next_exp_ff;
      pkt_seq_in   = pkt_seq_ff;
      pkt_fin_in   = pkt_fin_ff;
      pkt_size_in  = pkt_size_ff;
      pkt_tag_in   = pkt_tag_ff;
      iss_p_in     = iss_p_ff;
      iss_k_in     = iss_k_ff;
      chk_p_in     = chk_p_ff;
      chk_last_in  = chk_last_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_seq_in   = rsp_seq_ff;
      rsp_tag_in   = rsp_tag_ff;
      rsp_size_in  = rsp_size_ff;
      rsp_fin_in   = rsp_fin_ff;
      rsp_done_in  = rsp_done_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      seq_we       = 1'b0;
      seq_waddr    = head_ff;
      seq_wdata    = next_exp_ff;
      seq_re       = 1'b0;
      seq_raddr    = head_ff;
      dat_we       = 1'b0;
      dat_waddr    = chk_p_ff;
      dat_wdata    = '{tag: pkt_tag_ff, size: pkt_size_ff, fin: pkt_fin_ff};
      dat_re       = 1'b0;
      dat_raddr    = head_ff;

      unique case (state_ff)
         srrw_pkg::ST_INIT: begin
            // write expected seq of slot init_k, stop after W slots
            seq_we    = 1'b1;
            seq_waddr = init_k_ff;
            seq_wdata = init_s_ff;
            init_s_in = srrw_pkg::advance_seq(init_s_ff, seq_step_ff, seq_limit_ff);
            if (CNT_W'(init_k_ff) == win_len - CNT_W'(1)) begin
               next_exp_in = init_s_in;
               state_in    = srrw_pkg::ST_IDLE;
            end else begin
               init_k_in = init_k_ff + IDX_W'(1);
            end
         end
         srrw_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               pkt_seq_in  = req_pkt_seq;
               pkt_fin_in  = req_pkt_is_fin;
               pkt_size_in = req_pkt_size;
               pkt_tag_in  = req_pkt_tag;
               iss_p_in    = head_ff;
               iss_k_in    = '0;
               chk_vld_in  = 1'b0;
               state_in    = srrw_pkg::ST_SEARCH;
            end
         end
         srrw_pkg::ST_SEARCH: begin
            if (done_ff) begin
               // transfer finished: drop the item
               state_in = srrw_pkg::ST_IDLE;
            end else begin
               // issue one slot read a cycle, compare the one read last cycle
               chk_vld_in = 1'b0;
               if (iss_k_ff != win_len) begin
                  seq_re      = 1'b1;
                  seq_raddr   = iss_p_ff;
                  chk_p_in    = iss_p_ff;
                  chk_last_in = (iss_k_ff == win_len - CNT_W'(1));
                  chk_vld_in  = 1'b1;
                  iss_p_in    = wrap_inc(iss_p_ff, win_len);
                  iss_k_in    = iss_k_ff + CNT_W'(1);
               end
               if (chk_vld_ff) begin
                  if (seq_rdata_ff == pkt_seq_ff) begin
                     dat_we            = 1'b1;
                     rcvd_in[chk_p_ff] = 1'b1;
                     chk_vld_in        = 1'b0;
                     state_in          = srrw_pkg::ST_SL_RD;
                  end else if (chk_last_ff) begin
                     chk_vld_in = 1'b0;
                     state_in   = srrw_pkg::ST_SL_RD;
                  end
               end
            end
         end
         srrw_pkg::ST_SL_RD: begin
            if (rcvd_ff[head_ff]) begin
               seq_re   = 1'b1;
               dat_re   = 1'b1;
               state_in = srrw_pkg::ST_SL_OUT;
            end else begin
               state_in = srrw_pkg::ST_ACK;
            end
         end
         srrw_pkg::ST_SL_OUT: begin
            if (rsp_free) begin
               rsp_valid_in     = 1'b1;
               rsp_kind_in      = srrw_pkg::KIND_DELIVER;
               rsp_seq_in       = seq_rdata_ff;
               rsp_tag_in       = dat_rdata_ff.tag;
               rsp_size_in      = dat_rdata_ff.size;
               rsp_fin_in       = delivered_fin;
               rsp_done_in      = done_ff || delivered_fin;
               rsp_last_in      = 1'b0;
               done_in          = done_ff || delivered_fin;
               rcvd_in[head_ff] = 1'b0;
               // refill the head slot with the next expected seq
               seq_we           = 1'b1;
               next_exp_in      = srrw_pkg::advance_seq(next_exp_ff, seq_step_ff,
                                                        seq_limit_ff);
               head_in          = wrap_inc(head_ff, win_len);
               state_in         = srrw_pkg::ST_SL_RD;
            end
         end
         srrw_pkg::ST_ACK: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = srrw_pkg::KIND_ACK;
               rsp_seq_in   = pkt_seq_ff;
               rsp_tag_in   = '0;
               rsp_size_in  = '0;
               rsp_fin_in   = 1'b0;
               rsp_done_in  = done_ff;
               rsp_last_in  = 1'b1;
               state_in     = srrw_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = srrw_pkg::ST_IDLE;
         end
      endcase

      // write of a known register wins over item work and restarts the window
      if (csr_fire) begin
         unique case (csr_index)
            srrw_pkg::CSR_WINDOW_SLOTS: begin
               win_slots_in = csr_data[srrw_pkg::SLOTS_W-1:0];
               reinit       = 1'b1;
            end
            srrw_pkg::CSR_SEQ_STEP: begin
               seq_step_in = csr_data[srrw_pkg::STEP_W-1:0];
               reinit      = 1'b1;
            end
            srrw_pkg::CSR_SEQ_LIMIT: begin
               seq_limit_in = csr_data[srrw_pkg::SEQ_W-1:0];
               reinit       = 1'b1;
            end
            default: begin
               reinit = 1'b0;
            end
         endcase
      end
      if (reinit) begin
         state_in   = srrw_pkg::ST_INIT;
         init_k_in  = '0;
         init_s_in  = '0;
         head_in    = '0;
         done_in    = 1'b0;
         rcvd_in    = '0;
         chk_vld_in = 1'b0;
         seq_we     = 1'b0;
         dat_we     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= srrw_pkg::ST_INIT;
         win_slots_ff <= srrw_pkg::WINDOW_SLOTS_RST;
         seq_step_ff  <= srrw_pkg::SEQ_STEP_RST;
         seq_limit_ff <= srrw_pkg::SEQ_LIMIT_RST;
         init_k_ff    <= '0;
         init_s_ff    <= '0;
         head_ff      <= '0;
         done_ff      <= 1'b0;
         rcvd_ff      <= '0;
         chk_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         win_slots_ff <= win_slots_in;
         seq_step_ff  <= seq_step_in;
         seq_limit_ff <= seq_limit_in;
         init_k_ff    <= init_k_in;
         init_s_ff    <= init_s_in;
         head_ff      <= head_in;
         done_ff      <= done_in;
         rcvd_ff      <= rcvd_in;
         chk_vld_ff   <= chk_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      next_exp_ff <= next_exp_in;
      pkt_seq_ff  <= pkt_seq_in;
      pkt_fin_ff  <= pkt_fin_in;
      pkt_size_ff <= pkt_size_in;
      pkt_tag_ff  <= pkt_tag_in;
      iss_p_ff    <= iss_p_in;
      iss_k_ff    <= iss_k_in;
      chk_p_ff    <= chk_p_in;
      chk_last_ff <= chk_last_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_seq_ff  <= rsp_seq_in;
      rsp_tag_ff  <= rsp_tag_in;
      rsp_size_ff <= rsp_size_in;
      rsp_fin_ff  <= rsp_fin_in;
      rsp_done_ff <= rsp_done_in;
      rsp_last_ff <= rsp_last_in;
   end

   // slot seq memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (seq_we) begin
         seq_mem[seq_waddr] <= seq_wdata;
      end
      if (seq_re) begin
         seq_rdata_ff <= seq_mem[seq_raddr];
      end
   end

   // slot packet memory, written on a match, read at the head on a slide
   always_ff @(posedge clock) begin
      if (dat_we) begin
         dat_mem[dat_waddr] <= dat_wdata;
      end
      if (dat_re) begin
         dat_rdata_ff <= dat_mem[dat_raddr];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_result_kind   = rsp_kind_ff;
   assign rsp_out_seq       = rsp_seq_ff;
   assign rsp_out_tag       = rsp_tag_ff;
   assign rsp_out_size      = rsp_size_ff;
   assign rsp_out_is_fin    = rsp_fin_ff;
   assign rsp_transfer_done = rsp_done_ff;
   assign rsp_last_result   = rsp_last_ff;

endmodule
`default_nettype wire

// ----- sv/srrw_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srrw_port_checker
// Port-level checks of the receive window, bound to the top level.
// ----------------------------------------------------------------------------
`include "selective_repeat_receive_window_assert.svh"

module srrw_port_checker (
   input wire                            clock,
   input wire                            reset,
   input wire                            req_valid,
   input wire                            req_ready,
   input wire                            rsp_valid,
   input wire                            rsp_ready,
   input wire [srrw_pkg::SEQ_W-1:0]      rsp_out_seq,
   input wire                            rsp_last_result,
   input wire                            csr_valid,
   input wire                            csr_ready,
   input wire [srrw_pkg::CSR_INDEX_W-1:0] csr_index
);

   // init sweep follows reset
   `SRRW_ASSERT_NEXT_NR(a_reset_init, clock, reset, !req_ready, "ready right after reset")

   // one item at a time
   `SRRW_ASSERT_NEXT(a_one_item, clock, reset, req_valid && req_ready, !req_ready,
      "second item taken back to back")

   // write of a known register restarts the window
   `SRRW_ASSERT_NEXT(a_csr_init, clock, reset, csr_valid && csr_ready && (csr_index <= srrw_pkg::CSR_SEQ_LIMIT), !req_ready,
      "ready right after a register write")

   // stalled result holds
   `SRRW_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_out_seq) && $stable(rsp_last_result),
      "stalled result changed")

endmodule

bind selective_repeat_receive_window srrw_port_checker u_srrw_port_checker (.*);
`default_nettype wire
